/* design/mhb_pkg.sv */
package mhb_pkg;

  localparam int unsigned DEPTH_DEF = 1024;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_BUILD = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;
  localparam logic [1:0] FUNC_NOP   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] value;
    logic [10:0]        index;
  } in_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic [10:0]        count;
    logic [1:0]         status;
  } out_t;

endpackage

/* design/max_heap_builder.sv */
// Load: beat in the cycle after accept; one item per cycle if out_ready_i is high.
// Read: accept issues the memory read, S_READ registers its data; input stalled.
// Build: S_START reads a parent, S_LOADV takes it, S_LEFT/S_LWAIT/S_RWAIT move it
//   down, S_PLACE writes it; input stalled meanwhile.
// Reset (rst_ni low, asynchronous) clears the element count and the output beat;
//   store contents stay undefined until loaded.
module max_heap_builder #(
  parameter int unsigned DEPTH = mhb_pkg::DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mhb_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output mhb_pkg::out_t out_data_o
);

  import mhb_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  logic               we;
  logic [AW-1:0]      waddr;
  logic signed [31:0] wdata;
  logic               re;
  logic [AW-1:0]      raddr;
  logic signed [31:0] rdata;

  mhb_ctrl #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .re_o       (re),
    .raddr_o    (raddr),
    .rdata_i    (rdata)
  );

  mhb_mem #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

endmodule

/* design/mhb_mem.sv */
module mhb_mem #(
  parameter int unsigned DEPTH = mhb_pkg::DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic signed [31:0]   wdata_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        raddr_i,
  output logic signed [31:0]   rdata_o
);

  logic signed [31:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

/* design/mhb_ctrl.sv */
module mhb_ctrl #(
  parameter int unsigned DEPTH = mhb_pkg::DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  mhb_pkg::in_t         in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output mhb_pkg::out_t        out_data_o,
  output logic                 we_o,
  output logic [AW-1:0]        waddr_o,
  output logic signed [31:0]   wdata_o,
  output logic                 re_o,
  output logic [AW-1:0]        raddr_o,
  input  logic signed [31:0]   rdata_i
);

  import mhb_pkg::*;

  localparam int unsigned CNW = $clog2(DEPTH + 1);
  localparam int unsigned PW  = CNW + 1;
  localparam int unsigned XW  = (CNW > 11) ? CNW : 11;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_START,
    S_LOADV,
    S_LEFT,
    S_LWAIT,
    S_RWAIT,
    S_PLACE
  } state_e;

  state_e             state_q;
  logic [CNW-1:0]     count_q;
  logic [PW-1:0]      p_q;
  logic [PW-1:0]      pos_q;
  logic signed [31:0] v_q;
  logic signed [31:0] lv_q;
  logic               out_valid_q;
  out_t               out_q;

  logic               accept;
  logic               full;
  logic [XW-1:0]      idx_x;
  logic               range_err;
  logic               load_ok;
  logic               read_go;
  logic [1:0]         in_status;
  logic               out_set;
  logic [PW-1:0]      n_pw;
  logic [PW-1:0]      left;
  logic [PW-1:0]      right;
  logic               l_take;
  logic signed [31:0] cand;
  logic [PW-1:0]      cand_pos;
  logic               r_take;
  logic               take;

  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign full      = (count_q == CNW'(DEPTH));
  assign idx_x     = XW'(in_data_i.index);
  assign range_err = (idx_x == '0) || (idx_x > XW'(count_q));
  assign load_ok   = (in_data_i.func == FUNC_LOAD) && !full;
  assign read_go   = (in_data_i.func == FUNC_READ) && !range_err;
  assign in_status = ((in_data_i.func == FUNC_LOAD) && full) ? ST_FULL :
                     ((in_data_i.func == FUNC_READ) && range_err) ? ST_RANGE : ST_OK;
  assign out_set   = (accept && (in_data_i.func != FUNC_BUILD) && !read_go) ||
                     (state_q == S_READ) ||
                     ((state_q == S_START) && (p_q == '0));
  assign n_pw      = PW'(count_q);
  assign left      = {pos_q[PW-2:0], 1'b0};
  assign right     = {pos_q[PW-2:0], 1'b1};

  assign l_take   = lv_q > v_q;
  assign cand     = l_take ? lv_q : v_q;
  assign cand_pos = l_take ? left : pos_q;
  assign r_take   = rdata_i > cand;
  assign take     = l_take || r_take;

  always_comb begin
    we_o    = 1'b0;
    waddr_o = '0;
    wdata_o = '0;
    re_o    = 1'b0;
    raddr_o = '0;
    case (state_q)
      S_IDLE: begin
        if (accept && in_data_i.func == FUNC_LOAD && !full) begin
          we_o    = 1'b1;
          waddr_o = count_q[AW-1:0];
          wdata_o = in_data_i.value;
        end
        if (accept && in_data_i.func == FUNC_READ && !range_err) begin
          re_o    = 1'b1;
          raddr_o = AW'(idx_x - XW'(1));
        end
      end
      S_START: begin
        if (p_q != '0) begin
          re_o    = 1'b1;
          raddr_o = AW'(p_q - PW'(1));
        end
      end
      S_LEFT: begin
        if (left <= n_pw) begin
          re_o    = 1'b1;
          raddr_o = AW'(left - PW'(1));
        end
      end
      S_LWAIT: begin
        if (right <= n_pw) begin
          re_o    = 1'b1;
          raddr_o = AW'(right - PW'(1));
        end else if (rdata_i > v_q) begin
          we_o    = 1'b1;
          waddr_o = AW'(pos_q - PW'(1));
          wdata_o = rdata_i;
        end
      end
      S_RWAIT: begin
        if (take) begin
          we_o    = 1'b1;
          waddr_o = AW'(pos_q - PW'(1));
          wdata_o = r_take ? rdata_i : lv_q;
        end
      end
      S_PLACE: begin
        we_o    = 1'b1;
        waddr_o = AW'(pos_q - PW'(1));
        wdata_o = v_q;
      end
      default: begin
        we_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      p_q         <= '0;
      pos_q       <= '0;
      v_q         <= '0;
      lv_q        <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_set) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            out_q.data   <= '0;
            out_q.count  <= load_ok ? 11'(count_q + CNW'(1)) : 11'(count_q);
            out_q.status <= in_status;
            case (in_data_i.func)
              FUNC_LOAD: begin
                if (!full) begin
                  count_q <= count_q + CNW'(1);
                end
              end
              FUNC_BUILD: begin
                p_q     <= PW'(count_q >> 1);
                state_q <= S_START;
              end
              FUNC_READ: begin
                if (!range_err) begin
                  state_q <= S_READ;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_READ: begin
          out_q.data <= rdata_i;
          state_q    <= S_IDLE;
        end
        S_START: begin
          if (p_q == '0) begin
            state_q <= S_IDLE;
          end else begin
            pos_q   <= p_q;
            state_q <= S_LOADV;
          end
        end
        S_LOADV: begin
          v_q     <= rdata_i;
          state_q <= S_LEFT;
        end
        S_LEFT: begin
          state_q <= (left <= n_pw) ? S_LWAIT : S_PLACE;
        end
        S_LWAIT: begin
          lv_q <= rdata_i;
          if (right <= n_pw) begin
            state_q <= S_RWAIT;
          end else if (rdata_i > v_q) begin
            pos_q   <= left;
            state_q <= S_LEFT;
          end else begin
            state_q <= S_PLACE;
          end
        end
        S_RWAIT: begin
          if (take) begin
            pos_q   <= r_take ? right : cand_pos;
            state_q <= S_LEFT;
          end else begin
            state_q <= S_PLACE;
          end
        end
        S_PLACE: begin
          p_q     <= p_q - PW'(1);
          state_q <= S_START;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* design/mhb_checker.sv */
module mhb_checker #(
  parameter int unsigned DEPTH = mhb_pkg::DEPTH_DEF
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input mhb_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input mhb_pkg::out_t out_data_o
);

  import mhb_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output beat dropped or changed under stall");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_FULL |-> out_data_o.count == 11'(DEPTH))
    else $error("store full reported below depth");

  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |-> out_data_o.data == '0)
    else $error("error beat carries data");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.status <= ST_RANGE)
    else $error("unknown status code");

  a_load_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.func == FUNC_LOAD |=> out_valid_o)
    else $error("load beat not answered in the next cycle");

endmodule

bind max_heap_builder mhb_checker #(.DEPTH(DEPTH)) u_mhb_checker (.*);

/* sim/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mhb_pkg::*;

  localparam int unsigned DEPTH = DEPTH_DEF;
  localparam int unsigned RANDOM_ITEMS = 1950;
  localparam int unsigned QUIET_LIMIT = 50000;
  localparam int unsigned HOLD_AT = 300;
  localparam int unsigned HOLD_LEN = 400;
  localparam int unsigned CALM_LO = 700;
  localparam int unsigned CALM_HI = 900;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_beat = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_beat;

  in_t heap_op_q[$];
  out_t heap_reply_q[$];

  logic signed [31:0] mdl_store[1:DEPTH];
  int unsigned mdl_count = 0;

  int unsigned gen_count = 0;
  int unsigned gen_items = 0;
  int unsigned sent_cnt = 0;
  int unsigned recv_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned quiet_cycles = 0;
  int unsigned hold_left = 0;
  bit hold_done = 1'b0;
  out_t got_beat;
  out_t want_beat;

  max_heap_builder i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_beat),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_beat)
  );

  always #5 clk_i = ~clk_i;

  function automatic out_t heap_apply(in_t op);
    out_t res;
    int unsigned p;
    int unsigned pos;
    int unsigned lc;
    int unsigned rc;
    int unsigned big;
    logic signed [31:0] tmp;
    bit settled;
    res = '0;
    res.status = ST_OK;
    case (op.func)
      FUNC_LOAD: begin
        if (mdl_count >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          mdl_count++;
          mdl_store[mdl_count] = op.value;
        end
      end
      FUNC_BUILD: begin
        for (p = mdl_count / 2; p > 0; p--) begin
          pos = p;
          settled = 1'b0;
          while (!settled) begin
            lc = pos * 2;
            rc = lc + 1;
            big = pos;
            if (lc <= mdl_count && mdl_store[lc] > mdl_store[big]) big = lc;
            if (rc <= mdl_count && mdl_store[rc] > mdl_store[big]) big = rc;
            if (big == pos) begin
              settled = 1'b1;
            end else begin
              tmp = mdl_store[pos];
              mdl_store[pos] = mdl_store[big];
              mdl_store[big] = tmp;
              pos = big;
            end
          end
        end
      end
      FUNC_READ: begin
        if (op.index == 0 || op.index > mdl_count) begin
          res.status = ST_RANGE;
        end else begin
          res.data = mdl_store[op.index];
        end
      end
      default: begin
      end
    endcase
    res.count = mdl_count[10:0];
    return res;
  endfunction

  function automatic logic signed [31:0] rand_value();
    int v;
    case ($urandom_range(0, 9))
      0: v = 32'sh8000_0000;
      1: v = 32'sh7fff_ffff;
      2, 3: v = int'($urandom_range(0, 6)) - 3;
      default: v = int'($urandom);
    endcase
    return v;
  endfunction

  task automatic push_op(logic [1:0] func, logic signed [31:0] value, logic [10:0] index);
    in_t op;
    op.func = func;
    op.value = value;
    op.index = index;
    heap_op_q.push_back(op);
    gen_items++;
    if (func == FUNC_LOAD && gen_count < DEPTH) gen_count++;
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        heap_reply_q.push_back(heap_apply(in_beat));
        sent_cnt++;
      end
      if (!in_valid || in_ready) begin
        if (heap_op_q.size() > 0 &&
            ((sent_cnt >= CALM_LO && sent_cnt < CALM_HI) || $urandom_range(0, 99) >= 28)) begin
          in_valid <= 1'b1;
          in_beat <= heap_op_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got_beat = out_beat;
        recv_cnt++;
        if (heap_reply_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("unexpected beat: data=%0d count=%0d status=%0d",
                     got_beat.data, got_beat.count, got_beat.status);
          end
        end else begin
          want_beat = heap_reply_q.pop_front();
          if (got_beat.data !== want_beat.data || got_beat.count !== want_beat.count ||
              got_beat.status !== want_beat.status) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display({"beat %0d mismatch: data exp %0d got %0d, ",
                        "count exp %0d got %0d, status exp %0d got %0d"},
                       recv_cnt, want_beat.data, got_beat.data, want_beat.count,
                       got_beat.count, want_beat.status, got_beat.status);
            end
          end
        end
      end
      // hold off once so the block backs up into its input
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && recv_cnt == HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_LEN;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (recv_cnt >= CALM_LO && recv_cnt < CALM_HI) ||
                     $urandom_range(0, 99) >= 28;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk_i);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    int unsigned n;
    int unsigned i;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty store, unknown op, single element
    push_op(FUNC_READ, '0, 11'd1);
    push_op(FUNC_READ, '1, 11'd0);
    push_op(FUNC_BUILD, '0, '0);
    push_op(FUNC_NOP, '1, '1);
    push_op(FUNC_LOAD, 32'sh7fff_ffff, '1);
    push_op(FUNC_BUILD, '1, '0);
    push_op(FUNC_READ, '0, 11'd1);
    // extremes and equal keys
    push_op(FUNC_LOAD, 32'sh8000_0000, '0);
    push_op(FUNC_LOAD, 32'sd0, '0);
    push_op(FUNC_LOAD, -32'sd1, '0);
    push_op(FUNC_LOAD, 32'sd5, '0);
    push_op(FUNC_LOAD, 32'sd5, '0);
    push_op(FUNC_LOAD, 32'sd5, '0);
    push_op(FUNC_BUILD, '0, '0);
    for (i = 1; i <= 7; i++) push_op(FUNC_READ, '0, i[10:0]);
    push_op(FUNC_READ, '0, 11'd8);
    push_op(FUNC_READ, '0, 11'd2047);
    push_op(FUNC_READ, '0, 11'd0);

    // mostly load bursts, a build, then reads of the result; some noise
    while (gen_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 8) begin
        case ($urandom_range(0, 2))
          0: push_op(FUNC_NOP, rand_value(), 11'($urandom));
          1: push_op(FUNC_READ, rand_value(),
                     $urandom_range(0, 1) ? 11'd0 : 11'($urandom_range(gen_count + 1, 2047)));
          default: push_op(FUNC_BUILD, rand_value(), 11'($urandom));
        endcase
      end else begin
        n = $urandom_range(1, 12);
        for (i = 0; i < n; i++) push_op(FUNC_LOAD, rand_value(), 11'($urandom));
        if ($urandom_range(0, 99) < (gen_count < 128 ? 70 : 25)) begin
          push_op(FUNC_BUILD, rand_value(), 11'($urandom));
        end
        n = $urandom_range(1, 5);
        for (i = 0; i < n; i++) begin
          push_op(FUNC_READ, rand_value(), 11'($urandom_range(1, gen_count)));
        end
      end
    end

    while (heap_op_q.size() > 0 || in_valid || heap_reply_q.size() > 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (err_cnt == 0 && heap_reply_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* max_heap_builder.f */
design/mhb_pkg.sv
design/mhb_mem.sv
design/mhb_ctrl.sv
design/max_heap_builder.sv
design/mhb_checker.sv
sim/testbench.sv
